### rtl/core/jsw_pkg.sv
// shared constants and types for the jacobi symbol block
package jsw_pkg;

  // default word width of the arithmetic
  localparam int unsigned WORD_BITS_DEF = 64;

  // width of the input ports and of the symbol port
  localparam int unsigned IN_BITS  = 64;
  localparam int unsigned SYM_BITS = 2;

  // symbol codes, two's complement
  localparam logic signed [SYM_BITS-1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [SYM_BITS-1:0] SYM_POS  = 2'sb01;
  localparam logic signed [SYM_BITS-1:0] SYM_NEG  = 2'sb11;

  // residues that flip the sign: of the modulus mod 8, of both operands mod 4
  localparam logic [2:0] MOD8_FLIP_LO = 3'd3;
  localparam logic [2:0] MOD8_FLIP_HI = 3'd5;
  localparam logic [1:0] MOD4_FLIP    = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_FIN
  } jsw_state_t;

  // request from the sequencer to the remainder unit
  typedef struct packed {
    logic start;
  } jsw_div_req_t;

  // status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;
  } jsw_div_rsp_t;

endpackage

### rtl/core/jsw_rem_unit.sv
// iterative remainder unit: one quotient bit per cycle, restoring shift-subtract
module jsw_rem_unit
  import jsw_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jsw_div_req_t         req,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output jsw_div_rsp_t         rsp,
  output logic [WORD_BITS-1:0] remainder
);

  localparam int unsigned CW = $clog2(WORD_BITS);

  logic                 run_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [WORD_BITS-1:0] q_r;
  logic [WORD_BITS-1:0] d_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] rem_nxt;

  // shift in next dividend bit and subtract the divisor when it fits
  always_comb begin
    trial = {rem_r, q_r[WORD_BITS-1]};
    diff  = trial - {1'b0, d_r};
    if (trial >= {1'b0, d_r}) begin
      rem_nxt = diff[WORD_BITS-1:0];
    end else begin
      rem_nxt = trial[WORD_BITS-1:0];
    end
  end

  // control: run flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(WORD_BITS - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= {q_r[WORD_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done  = done_r;
  assign remainder = rem_r;

endmodule

### rtl/core/jacobi_symbol_word_top.sv
// jacobi symbol of a word value over a word modulus, sequencer and top level
//
// Usage: drive in_value and in_modulus and raise start while busy is low;
// that edge accepts the transaction and busy rises on the next cycle. Only
// the low WORD_BITS bits of each input take part. When the loop ends,
// out_valid is high for exactly one cycle with out_symbol set to -1, 0 or 1
// (two's complement); busy falls in that same cycle, so a new start may be
// given there.
// Sequence: factors of two are stripped in ST_STRIP, one per cycle, and
// each swap starts a reduction in ST_DIV. Each reduction runs the shared
// remainder unit, one quotient bit per cycle. The block takes one
// transaction at a time.
// Reset: synchronous, active low; returns to idle and drops out_valid.
// The receiver cannot stall: a result not taken in its strobe cycle is gone.
module jacobi_symbol_word_top
  import jsw_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [IN_BITS-1:0]         in_value,
  input  logic [IN_BITS-1:0]         in_modulus,
  output logic                       out_valid,
  output logic signed [SYM_BITS-1:0] out_symbol
);

  jsw_state_t           state_r, state_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic                 neg_r, neg_nxt;
  logic                 valid_r, valid_nxt;
  logic signed [SYM_BITS-1:0] sym_r, sym_nxt;
  logic                 div_go_r;
  jsw_div_req_t         div_req;
  jsw_div_rsp_t         div_rsp;
  logic [WORD_BITS-1:0] div_rem;

  // shared remainder unit: dividend is the old modulus, divisor the odd value
  jsw_rem_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (a_r),
    .divisor   (m_r),
    .rsp       (div_rsp),
    .remainder (div_rem)
  );

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    valid_nxt     = 1'b0;
    sym_nxt       = sym_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt     = in_value[WORD_BITS-1:0];
          m_nxt     = in_modulus[WORD_BITS-1:0];
          neg_nxt   = 1'b0;
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (a_r == '0) begin
          state_nxt = ST_FIN;
        end else if (!a_r[0]) begin
          // remove one factor of two
          a_nxt = a_r >> 1;
          if (m_r[2:0] inside {MOD8_FLIP_LO, MOD8_FLIP_HI}) begin
            neg_nxt = !neg_r;
          end
        end else begin
          // exchange and start the reduction
          a_nxt = m_r;
          m_nxt = a_r;
          if (a_r[1:0] == MOD4_FLIP && m_r[1:0] == MOD4_FLIP) begin
            neg_nxt = !neg_r;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          a_nxt     = div_rem;
          state_nxt = ST_STRIP;
        end
      end
      ST_FIN: begin
        valid_nxt = 1'b1;
        if (m_r != WORD_BITS'(1)) begin
          sym_nxt = SYM_ZERO;
        end else if (neg_r) begin
          sym_nxt = SYM_NEG;
        end else begin
          sym_nxt = SYM_POS;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // one-cycle start pulse once the swapped operands are in place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r <= 1'b0;
    end else begin
      div_go_r <= (state_r == ST_STRIP) && (state_nxt == ST_DIV);
    end
  end

  assign div_req.start = div_go_r;

  // payload registers
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    m_r   <= m_nxt;
    neg_r <= neg_nxt;
    sym_r <= sym_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = valid_r;
  assign out_symbol = sym_r;

endmodule
